// ===== design/lcdsb_pkg.sv =====
// Shared types and constants for the character LCD shadow buffer.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package lcdsb_pkg;

  // Blank character loaded by a clear
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOCATE  = 2'd1,
    OP_WRITE   = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef enum logic {
    KIND_POS  = 1'b0,
    KIND_DATA = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_ROW,
    S_RD,
    S_CMP,
    S_POS,
    S_DAT,
    S_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic clr_step;
    logic emit_row_pos;
    logic emit_cell_pos;
    logic emit_data;
    logic skip_cell;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  in_op;
    logic clr_last;
    logic differ;
    logic prev_chg;
    logic col_last;
    logic row_last;
    logic emit_ok;
    logic flush_ok;
  } sts_t;

endpackage

// ===== design/lcdsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lcdsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lcdsb_ctrl.sv =====
// Sequencing state machine of the shadow buffer: accepts items, runs the
// clear sweep and the refresh scan. Depends on lcdsb_pkg.
`timescale 1ns / 1ps

module lcdsb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lcdsb_pkg::sts_t   sts,
  output lcdsb_pkg::cmd_t   cmd
);
  import lcdsb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        // Hold off the input while reset is asserted
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.take = 1'b1;
          if (sts.in_op == OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (sts.in_op == OP_REFRESH) begin
            state_nxt = S_ROW;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_ROW: begin
        if (sts.emit_ok) begin
          cmd.emit_row_pos = 1'b1;
          state_nxt        = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.differ) begin
          state_nxt = sts.prev_chg ? S_DAT : S_POS;
        end else begin
          cmd.skip_cell = 1'b1;
          if (sts.col_last && sts.row_last) begin
            state_nxt = S_FLUSH;
          end else if (sts.col_last) begin
            state_nxt = S_ROW;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_POS: begin
        if (sts.emit_ok) begin
          cmd.emit_cell_pos = 1'b1;
          state_nxt         = S_DAT;
        end
      end
      S_DAT: begin
        if (sts.emit_ok) begin
          cmd.emit_data = 1'b1;
          if (sts.col_last && sts.row_last) begin
            state_nxt = S_FLUSH;
          end else if (sts.col_last) begin
            state_nxt = S_ROW;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_FLUSH: begin
        if (sts.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lcdsb_datapath.sv =====
// Datapath of the shadow buffer: cursor, scan counters, pending and shown
// RAMs with valid bits, hold stage and output register.
// Depends on lcdsb_pkg and lcdsb_ram.
`timescale 1ns / 1ps

module lcdsb_datapath #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_op,
  input  logic [7:0]      in_row,
  input  logic [7:0]      in_column,
  input  logic [7:0]      in_character,
  input  lcdsb_pkg::cmd_t cmd,
  output lcdsb_pkg::sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_kind,
  output logic            out_row,
  output logic [3:0]      out_column,
  output logic [7:0]      out_data,
  output logic            out_last
);
  import lcdsb_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS);

  op_t op;

  logic [7:0]       cur_row_r, cur_row_nxt;
  logic [7:0]       cur_col_r, cur_col_nxt;
  logic [RW-1:0]    scan_row_r, scan_row_nxt;
  logic [CW-1:0]    scan_col_r, scan_col_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             prev_chg_r, prev_chg_nxt;
  logic [CELLS-1:0] pvalid_r, pvalid_nxt;
  logic [CELLS-1:0] svalid_r, svalid_nxt;
  logic             pv_q_r, sv_q_r;

  logic             hold_v_r, hold_v_nxt;
  logic             hold_kind_r, hold_row_r;
  logic [3:0]       hold_col_r;
  logic [7:0]       hold_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_row_r, out_last_r;
  logic [3:0]       out_col_r;
  logic [7:0]       out_data_r;

  logic             in_range;
  logic             wr_cell;
  logic [AW-1:0]    wr_addr, scan_addr;
  logic             p_we;
  logic [AW-1:0]    p_waddr;
  logic [7:0]       p_wdata;
  logic [7:0]       p_rdata, s_rdata;
  logic [7:0]       pend_byte, shown_byte;
  logic             any_emit, emit_ok, flush_ok, col_last, row_last;
  logic             new_kind, new_row;
  logic [3:0]       new_col;
  logic [7:0]       new_data;
  logic [7:0]       scan_col_w;

  assign op        = op_t'(in_op);
  assign in_range  = (cur_row_r < 8'(ROWS)) && (cur_col_r < 8'(COLUMNS));
  assign wr_cell   = cmd.take && (op == OP_WRITE) && in_range;
  assign wr_addr   = AW'(32'(cur_row_r) * COLUMNS + 32'(cur_col_r));
  assign scan_addr = AW'(32'(scan_row_r) * COLUMNS + 32'(scan_col_r));
  assign col_last  = scan_col_r == CW'(COLUMNS - 1);
  assign row_last  = scan_row_r == RW'(ROWS - 1);

  // Pending RAM write port: clear sweep or character write
  assign p_we    = cmd.clr_step || wr_cell;
  assign p_waddr = cmd.clr_step ? clr_cnt_r : wr_addr;
  assign p_wdata = cmd.clr_step ? BLANK_CHAR : in_character;

  lcdsb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_pending (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (scan_addr),
    .rdata (p_rdata)
  );

  lcdsb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_shown (
    .clk   (clk),
    .we    (cmd.emit_data),
    .waddr (scan_addr),
    .wdata (pend_byte),
    .raddr (scan_addr),
    .rdata (s_rdata)
  );

  // Entries never written read as zero
  assign pend_byte  = pv_q_r ? p_rdata : 8'h00;
  assign shown_byte = sv_q_r ? s_rdata : 8'h00;

  assign emit_ok  = !hold_v_r || !out_valid_r || out_ready;
  assign flush_ok = !out_valid_r || out_ready;
  assign any_emit = cmd.emit_row_pos || cmd.emit_cell_pos || cmd.emit_data;

  assign scan_col_w = 8'(scan_col_r);

  always_comb begin
    new_kind = KIND_POS;
    new_row  = scan_row_r[0];
    new_col  = 4'd0;
    new_data = 8'h00;
    if (cmd.emit_cell_pos) begin
      new_col = scan_col_w[3:0];
    end else if (cmd.emit_data) begin
      new_kind = KIND_DATA;
      new_row  = 1'b0;
      new_data = pend_byte;
    end
  end

  // Control state next values
  always_comb begin
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    clr_cnt_nxt  = clr_cnt_r;
    prev_chg_nxt = prev_chg_r;
    pvalid_nxt   = pvalid_r;
    svalid_nxt   = svalid_r;

    if (cmd.take) begin
      case (op)
        OP_CLEAR: begin
          cur_row_nxt = 8'd0;
          cur_col_nxt = 8'd0;
          clr_cnt_nxt = '0;
        end
        OP_LOCATE: begin
          cur_row_nxt = in_row;
          cur_col_nxt = in_column;
        end
        OP_WRITE: begin
          if (in_range) begin
            if (cur_col_r == 8'(COLUMNS - 1)) begin
              cur_col_nxt = 8'd0;
              cur_row_nxt = (cur_row_r == 8'(ROWS - 1)) ? 8'd0 : cur_row_r + 8'd1;
            end else begin
              cur_col_nxt = cur_col_r + 8'd1;
            end
          end
        end
        OP_REFRESH: begin
          scan_row_nxt = '0;
          scan_col_nxt = '0;
        end
        default: begin
          cur_row_nxt = cur_row_r;
        end
      endcase
    end

    if (wr_cell) begin
      pvalid_nxt[wr_addr] = 1'b1;
    end

    if (cmd.clr_step) begin
      pvalid_nxt[clr_cnt_r] = 1'b1;
      clr_cnt_nxt           = clr_cnt_r + AW'(1);
    end

    if (cmd.emit_data || cmd.skip_cell) begin
      prev_chg_nxt = cmd.emit_data;
      if (cmd.emit_data) begin
        svalid_nxt[scan_addr] = 1'b1;
      end
      // Step to the next cell; on the final cell the column wraps to zero and the row stays
      if (col_last) begin
        scan_col_nxt = '0;
        if (!row_last) begin
          scan_row_nxt = scan_row_r + RW'(1);
        end
      end else begin
        scan_col_nxt = scan_col_r + CW'(1);
      end
    end
  end

  // Hold stage and output register handshake
  always_comb begin
    hold_v_nxt    = hold_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (any_emit) begin
      hold_v_nxt = 1'b1;
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
      end
    end else if (cmd.flush) begin
      hold_v_nxt    = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= 8'd0;
      cur_col_r   <= 8'd0;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      clr_cnt_r   <= '0;
      prev_chg_r  <= 1'b0;
      pvalid_r    <= '0;
      svalid_r    <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      prev_chg_r  <= prev_chg_nxt;
      pvalid_r    <= pvalid_nxt;
      svalid_r    <= svalid_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pv_q_r <= pvalid_r[scan_addr];
    sv_q_r <= svalid_r[scan_addr];
    if (any_emit) begin
      hold_kind_r <= new_kind;
      hold_row_r  <= new_row;
      hold_col_r  <= new_col;
      hold_data_r <= new_data;
    end
    if ((any_emit && hold_v_r) || cmd.flush) begin
      out_kind_r <= hold_kind_r;
      out_row_r  <= hold_row_r;
      out_col_r  <= hold_col_r;
      out_data_r <= hold_data_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_row    = out_row_r;
  assign out_column = out_col_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  always_comb begin
    sts          = '0;
    sts.in_op    = op;
    sts.clr_last = clr_cnt_r == AW'(CELLS - 1);
    sts.differ   = pend_byte != shown_byte;
    sts.prev_chg = prev_chg_r;
    sts.col_last = col_last;
    sts.row_last = row_last;
    sts.emit_ok  = emit_ok;
    sts.flush_ok = flush_ok;
  end

  // An emit never drops a result still waiting in the output register
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    any_emit |-> emit_ok)
    else $error("emit issued with no room in output path");

  // A flush always presents the final command of the run
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (out_valid_r && out_last_r))
    else $error("flush did not present a last command");

  // A write with the cursor off the display leaves the cursor alone
  a_write_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && (op == OP_WRITE) && !in_range) |=>
      ($stable(cur_row_r) && $stable(cur_col_r)))
    else $error("out-of-range write moved the cursor");

  // A flush only follows a run that left a command in the hold stage
  a_flush_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> hold_v_r)
    else $error("flush with empty hold stage");

endmodule

// ===== design/char_lcd_shadow_buffer_refresh_top.sv =====
// Top level of the character LCD shadow frame buffer with differential refresh.
// Depends on lcdsb_pkg, lcdsb_ctrl, lcdsb_datapath and lcdsb_ram.
`timescale 1ns / 1ps
//
// Usage:
//   The input stream carries one operation per transaction: clear, locate,
//   write character or refresh. A refresh produces a run of display commands
//   on the output stream (set position or data byte); the final command of
//   the run has out_tlast set. Other operations produce no commands.
//   Rate: locate and write items stream at one per cycle. A clear runs a
//   fill sweep over the pending RAM, one cell per cycle through its single
//   write port. A refresh emits a start command per row, steps through RAM
//   read and compare for each unchanged cell and through read, compare,
//   optional position and data for each changed cell, and ends with a
//   flush. Each command first enters a one-deep hold stage so that the
//   last one can be tagged, so a command reaches the output one emit
//   later, the final one on the flush.
//   The next item is taken once the scan or sweep finishes; the last results
//   may still wait in the output register.
//   Reset: both buffers read as zero (per-cell valid bits), cursor at the
//   origin, match flag cleared, no item accepted in the reset cycle.
//   Stall: once hold stage and output register are full, a low out_tready holds the scan at its next command.

module char_lcd_shadow_buffer_refresh_top #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row[7:0], column[15:8], character[23:16]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_row[0], out_column[4:1], out_data[12:5], zero[15:13]
  output logic        out_tuser,  // command_kind[0]
  output logic        out_tlast
);
  import lcdsb_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       o_row;
  logic [3:0] o_col;
  logic [7:0] o_data;

  // Sequence the operations
  lcdsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold buffers, cursor and output path
  lcdsb_datapath #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_tuser),
    .in_row       (in_tdata[7:0]),
    .in_column    (in_tdata[15:8]),
    .in_character (in_tdata[23:16]),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_tuser),
    .out_row      (o_row),
    .out_column   (o_col),
    .out_data     (o_data),
    .out_last     (out_tlast)
  );

  // Pack the result fields from the lowest bit up
  assign out_tdata = {3'b000, o_data, o_col, o_row};

endmodule

// ===== sim/char_lcd_shadow_buffer_refresh_top_tb.sv =====
// Self-checking bench for the character LCD shadow buffer with differential refresh.
// Depends on lcdsb_pkg and char_lcd_shadow_buffer_refresh_top; a tracker class mirrors
// both cell buffers, the cursor and the match flag to predict every display command.
`timescale 1ns / 1ps

module char_lcd_shadow_buffer_refresh_top_tb;
  import lcdsb_pkg::*;

  localparam int ROWS      = 2;
  localparam int COLUMNS   = 16;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int RAND_OPS  = 110;
  localparam int HOLD_LEN  = 400;     // long receiver hold-off, in cycles
  localparam int DRAIN_LEN = 60;      // quiet cycles after the last command
  localparam int LIMIT     = 500000;  // cycle budget for the whole run

  // One display command as seen on the output stream
  typedef struct packed {
    kind_t      kind;
    logic       row;
    logic [3:0] col;
    logic [7:0] data;
    logic       last;
  } lcd_cmd_t;

  // Mirror of the shadow buffer; queues the commands each refresh must produce
  class lcd_refresh_tracker;
    logic [7:0] pending [CELLS];
    logic [7:0] shown [CELLS];
    logic [7:0] cur_row;
    logic [7:0] cur_col;
    bit         prev_changed;
    lcd_cmd_t   due_cmds [$];
    int         errors;

    function new();
      for (int i = 0; i < CELLS; i++) begin
        pending[i] = 8'h00;
        shown[i]   = 8'h00;
      end
      cur_row      = 8'd0;
      cur_col      = 8'd0;
      prev_changed = 1'b0;
      errors       = 0;
    endfunction

    function void push_cmd(kind_t kind, logic row, logic [3:0] col, logic [7:0] data);
      lcd_cmd_t c;
      c.kind = kind;
      c.row  = row;
      c.col  = col;
      c.data = data;
      c.last = 1'b0;
      due_cmds.push_back(c);
    endfunction

    // Apply one accepted operation to the mirror
    function void take_item(op_t op, logic [7:0] row, logic [7:0] col, logic [7:0] ch);
      int idx;
      int first;
      lcd_cmd_t c;
      case (op)
        OP_CLEAR: begin
          for (int i = 0; i < CELLS; i++) pending[i] = BLANK_CHAR;
          cur_row = 8'd0;
          cur_col = 8'd0;
        end
        OP_LOCATE: begin
          cur_row = row;
          cur_col = col;
        end
        OP_WRITE: begin
          if (cur_row < ROWS && cur_col < COLUMNS) begin
            pending[cur_row * COLUMNS + cur_col] = ch;
            cur_col = cur_col + 8'd1;
            if (cur_col == COLUMNS) begin
              cur_col = 8'd0;
              cur_row = cur_row + 8'd1;
              if (cur_row == ROWS) cur_row = 8'd0;
            end
          end
        end
        default: begin
          first = due_cmds.size();
          for (int r = 0; r < ROWS; r++) begin
            push_cmd(KIND_POS, r[0], 4'd0, 8'h00);
            for (int j = 0; j < COLUMNS; j++) begin
              idx = r * COLUMNS + j;
              if (pending[idx] != shown[idx]) begin
                if (!prev_changed) push_cmd(KIND_POS, r[0], j[3:0], 8'h00);
                push_cmd(KIND_DATA, 1'b0, 4'd0, pending[idx]);
                shown[idx]   = pending[idx];
                prev_changed = 1'b1;
              end else begin
                prev_changed = 1'b0;
              end
            end
          end
          if (due_cmds.size() > first) begin
            c = due_cmds.pop_back();
            c.last = 1'b1;
            due_cmds.push_back(c);
          end
        end
      endcase
    endfunction

    // Compare one output transaction with the oldest queued command
    function void match_cmd(logic kind, logic row, logic [3:0] col, logic [7:0] data,
                            logic [2:0] pad, logic last);
      lcd_cmd_t c;
      if (due_cmds.size() == 0) begin
        $display("%0t: unexpected command kind %h row %h col %h data %h last %h",
                 $time, kind, row, col, data, last);
        errors++;
        return;
      end
      c = due_cmds.pop_front();
      if (kind !== c.kind) begin
        $display("%0t: kind expected %h actual %h", $time, c.kind, kind);
        errors++;
      end
      if (row !== c.row) begin
        $display("%0t: row expected %h actual %h", $time, c.row, row);
        errors++;
      end
      if (col !== c.col) begin
        $display("%0t: column expected %h actual %h", $time, c.col, col);
        errors++;
      end
      if (data !== c.data) begin
        $display("%0t: data expected %h actual %h", $time, c.data, data);
        errors++;
      end
      if (pad !== 3'b000) begin
        $display("%0t: tdata padding expected %h actual %h", $time, 3'b000, pad);
        errors++;
      end
      if (last !== c.last) begin
        $display("%0t: last expected %h actual %h", $time, c.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = 24'd0;  // row[7:0], column[15:8], character[23:16]
  logic [1:0]  in_tuser   = 2'd0;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // out_row[0], out_column[4:1], out_data[12:5], zero[15:13]
  logic        out_tuser;           // command_kind[0]
  logic        out_tlast;

  lcd_refresh_tracker tracker = new();

  int  cmds_seen      = 0;
  int  cycle_count    = 0;
  bit  long_hold_done = 1'b0;
  bit  steady         = 1'b0;   // suppress idling on both sides while set

  char_lcd_shadow_buffer_refresh_top #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one operation and hold it until the transaction completes.
  // Valid is lowered only when a gap precedes the item, so it never drops
  // and rises in the same time step.
  task automatic send_op(op_t op, logic [7:0] row, logic [7:0] col, logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {ch, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_item(op, row, col, ch);
  endtask

  task automatic locate(logic [7:0] row, logic [7:0] col);
    send_op(OP_LOCATE, row, col, 8'($urandom_range(0, 255)));
  endtask

  task automatic put_char(logic [7:0] ch);
    send_op(OP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ch);
  endtask

  task automatic blank_all();
    send_op(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)));
  endtask

  task automatic refresh();
    send_op(OP_REFRESH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)));
  endtask

  // Receiver: random ready pattern, plus one long hold-off once commands
  // are flowing so the scan stalls and the input backs up behind it.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && cmds_seen >= 40) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Check every output transaction against the mirror
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_cmd(out_tuser, out_tdata[0], out_tdata[4:1], out_tdata[12:5],
                        out_tdata[15:13], out_tlast);
      cmds_seen++;
    end
  end

  // Watchdog: end the run if it overruns the cycle budget
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int r;
    logic [7:0] ch;

    // Hold reset, then release at a clock edge
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refresh straight out of reset sees two zeroed buffers
    refresh();
    // Clear then refresh: every cell changes, one unbroken run of data
    blank_all();
    refresh();
    // Nothing changed: row starts only
    refresh();
    // Cursor outside the display: writes are dropped
    locate(8'hFF, 8'hFF);
    put_char(8'hAA);
    locate(8'd2, 8'd0);
    put_char(8'h41);
    locate(8'd0, 8'd16);
    put_char(8'h42);
    // Last cell, then wrap to the origin; a blank matches the shown copy
    locate(8'd1, 8'd15);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(BLANK_CHAR);
    // Changed run that crosses the row boundary keeps the flag set
    locate(8'd0, 8'd14);
    put_char(8'h55);
    put_char(8'h56);
    put_char(8'h57);
    refresh();
    // Alternating bit patterns in an out of range locate
    locate(8'hAA, 8'h55);
    put_char(8'h33);
    locate(8'h55, 8'hAA);
    // Clear leaves the shown copy and the match flag alone
    blank_all();
    refresh();

    // Random: mostly writes at in-range cursors, some refreshes, a little noise
    for (int n = 0; n < RAND_OPS; n++) begin
      steady = (n >= 50 && n < 75);
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
        ch = 8'($urandom_range(0, 255));
      end else begin
        case ($urandom_range(0, 2))
          0:       ch = BLANK_CHAR;
          1:       ch = 8'h41;
          default: ch = 8'h42;
        endcase
      end
      if (r < 6) begin
        blank_all();
      end else if (r < 24) begin
        if ($urandom_range(0, 4) != 0)
          locate(8'($urandom_range(0, ROWS - 1)), 8'($urandom_range(0, COLUMNS - 1)));
        else
          locate(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (r < 84) begin
        put_char(ch);
      end else begin
        refresh();
      end
    end
    steady = 1'b0;
    refresh();

    // Drop valid and wait for the queued commands, then stay quiet a while
    in_tvalid <= 1'b0;
    while (tracker.due_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    if (tracker.errors == 0 && tracker.due_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lcdsb_pkg.sv
design/lcdsb_ram.sv
design/lcdsb_ctrl.sv
design/lcdsb_datapath.sv
design/char_lcd_shadow_buffer_refresh_top.sv
sim/char_lcd_shadow_buffer_refresh_top_tb.sv
